// ----- hw/rtl/sfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the serial frame deframer
// Header bytes, CRC-16 constants, frame offsets and the queue entry format.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam logic [7:0]  HDR_FIRST  = 8'hA5;
	localparam logic [7:0]  HDR_SECOND = 8'h5A;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;

	// Frame index width: L+26 must fit
	localparam int unsigned POS_W = 17;
	// Last CRC-covered byte is L+23, last frame byte is L+26
	localparam logic [POS_W-1:0] CRC_END_OFS = 17'd23;
	localparam logic [POS_W-1:0] LAST_OFS    = 17'd26;
	localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd2;
	localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd3;
	localparam logic [POS_W-1:0] POS_BODY    = 17'd4;

	// One queued word; pair marks the 5A word, which is preceded by the A5 on output
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       good;
		logic       pair;
	} sfd_entry_t;

	typedef struct packed {
		logic       valid;
		sfd_entry_t entry;
	} sfd_push_t;

	// Byte-wide reflected CRC-16 update, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sfd_rx_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_rx_if: received byte channel
// Valid/ready handshake carrying one serial byte per word.
// ----------------------------------------------------------------------------
interface sfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sfd_frame_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_frame_if: frame byte channel
// Valid/ready handshake carrying one frame byte with its marks per word.
// ----------------------------------------------------------------------------
interface sfd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       first_of_frame;
	logic       last_of_frame;
	logic       frame_good;

	modport source (output valid, output frame_byte, output first_of_frame,
		output last_of_frame, output frame_good, input ready);
	modport sink (input valid, input frame_byte, input first_of_frame,
		input last_of_frame, input frame_good, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sfd_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_core: header hunt, length capture and CRC check
// Registers the accepted byte, runs the frame FSM on it and pushes at most
// one queue word per cycle.
// ----------------------------------------------------------------------------
module sfd_core
	import sfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] rx_byte,
	output sfd_push_t       push
);

	typedef enum logic [4:0] {
		PH_HUNT   = 5'b00001,
		PH_SAW_A5 = 5'b00010,
		PH_LEN_LO = 5'b00100,
		PH_LEN_HI = 5'b01000,
		PH_BODY   = 5'b10000
	} phase_t;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	phase_t           phase_q, phase_d;
	logic [15:0]      len_q, len_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       crc_lo_q, crc_lo_d;
	logic             mis_q, mis_d;
	logic [POS_W-1:0] len_ext;
	logic [POS_W-1:0] crc_end;
	logic [POS_W-1:0] last_pos;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	assign len_ext  = {1'b0, len_q};
	assign crc_end  = len_ext + CRC_END_OFS;
	assign last_pos = len_ext + LAST_OFS;

	// Frame FSM
	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		pos_d    = pos_q;
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		mis_d    = mis_q;
		push     = '0;
		if (valid_s1) begin
			case (phase_q)
				PH_SAW_A5: begin
					if (byte_s1 == HDR_SECOND) begin
						push.valid      = 1'b1;
						push.entry.data = HDR_SECOND;
						push.entry.pair = 1'b1;
						phase_d  = PH_LEN_LO;
						pos_d    = POS_LEN_LO;
						crc_d    = CRC_INIT;
						mis_d    = 1'b0;
						crc_lo_d = 8'h00;
					end else if (byte_s1 == HDR_FIRST) begin
						phase_d = PH_SAW_A5;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_LEN_LO: begin
					len_d           = {8'h00, byte_s1};
					crc_d           = crc16_byte(crc_q, byte_s1);
					pos_d           = POS_LEN_HI;
					phase_d         = PH_LEN_HI;
					push.valid      = 1'b1;
					push.entry.data = byte_s1;
				end
				PH_LEN_HI: begin
					len_d           = {byte_s1, len_q[7:0]};
					crc_d           = crc16_byte(crc_q, byte_s1);
					pos_d           = POS_BODY;
					phase_d         = PH_BODY;
					push.valid      = 1'b1;
					push.entry.data = byte_s1;
				end
				PH_BODY: begin
					// CRC over body, then capture and compare the trailer
					if (pos_q <= crc_end) begin
						crc_d = crc16_byte(crc_q, byte_s1);
					end else if (pos_q == crc_end + 17'd1) begin
						crc_lo_d = byte_s1;
					end else if (pos_q == crc_end + 17'd2) begin
						mis_d = (crc_lo_q != crc_q[7:0]) || (byte_s1 != crc_q[15:8]);
					end
					push.valid      = 1'b1;
					push.entry.data = byte_s1;
					if (pos_q >= last_pos) begin
						push.entry.last = 1'b1;
						push.entry.good = ~mis_d;
						phase_d         = PH_HUNT;
						pos_d           = '0;
					end else begin
						pos_d = pos_q + 17'd1;
					end
				end
				default: begin
					phase_d = (byte_s1 == HDR_FIRST) ? PH_SAW_A5 : PH_HUNT;
				end
			endcase
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			len_q    <= '0;
			pos_q    <= '0;
			crc_q    <= CRC_INIT;
			crc_lo_q <= '0;
			mis_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			pos_q    <= pos_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			mis_q    <= mis_d;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sfd_outq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_outq: result queue
// Small register queue between the FSM and the output channel. A header
// word expands into two output words (A5 then 5A).
// ----------------------------------------------------------------------------
module sfd_outq
	import sfd_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire sfd_push_t  push,
	output logic            room,
	sfd_frame_if.source     tx
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	sfd_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             half_q;
	sfd_entry_t       head;
	logic             fire;
	logic             pop;
	logic             hdr_half;

	assign head     = mem_q[rd_ptr_q];
	assign hdr_half = head.pair & ~half_q;
	assign fire     = tx.valid & tx.ready;
	assign pop      = fire & ~hdr_half;

	// Two free slots: one for the byte in the input register, one for a new byte
	assign room = count_q <= CNT_W'(DEPTH - 2);

	// Output word: A5 first on a header entry, then the entry itself
	assign tx.valid          = count_q != '0;
	assign tx.frame_byte     = hdr_half ? HDR_FIRST : head.data;
	assign tx.first_of_frame = hdr_half;
	assign tx.last_of_frame  = hdr_half ? 1'b0 : head.last;
	assign tx.frame_good     = hdr_half ? 1'b0 : head.good;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	// Pointers, fill count and header half mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			half_q   <= 1'b0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push.valid && pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (fire) begin
				half_q <= hdr_half;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/serial_frame_deframer_crc16.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_deframer_crc16: serial byte deframer with CRC-16 check
// rx carries received serial bytes, one per word. The block hunts for the
// header A5 5A, reads a little-endian length L and streams all L+27 frame
// bytes on tx. first_of_frame marks the A5, last_of_frame marks byte L+26,
// and frame_good on that byte is 1 when the CRC-16 (init FFFF, reflected
// poly A001) over bytes 2..L+23 equals bytes L+24 (low) and L+25 (high).
// Bytes outside a frame produce no words; downstream drops bad frames.
// Throughput: one rx byte per cycle while the output queue has room. A
// header emits two words for the 5A byte, so tx briefly runs one word
// behind; the output queue absorbs that and idle line bytes drain it.
// An accepted byte passes through the input register and the output queue to tx.
// rx.ready is high while the output queue has two free slots; when tx
// stalls the queue fills and rx.ready drops, no byte is lost.
// Reset clears the FSM to header hunt and empties the queue.
// ----------------------------------------------------------------------------
module serial_frame_deframer_crc16
	import sfd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sfd_rx_if.sink      rx,
	sfd_frame_if.source tx
);

	logic      accept;
	logic      room;
	sfd_push_t push;

	assign rx.ready = room;
	assign accept   = rx.valid & room;

	sfd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx.rx_byte),
		.push    (push)
	);

	sfd_outq #(
		.DEPTH (QUEUE_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tx     (tx)
	);

endmodule
`default_nettype wire

// ----- tb/sv/tb_serial_frame_deframer_crc16.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_deframer_crc16: self-checking bench for the serial deframer
// Streams serial bytes into rx: idle-line noise, broken headers, and frames
// with good or damaged CRC-16. A scoreboard class tracks the header hunt,
// length and CRC of every frame and checks each tx word in order. Both sides
// idle at random; a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_crc16;
	import sfd_pkg::*;

	localparam int BYTE_TARGET    = 620;
	localparam int GAP_MAX        = 13;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 16;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SAW_A5,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_BODY
	} deframe_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       good;
	} frame_word_t;

	// Tracks the deframer state and holds the tx words still owed
	class frame_scoreboard;
		frame_word_t    pending_words[$];
		deframe_phase_t phase;
		logic [15:0]    payload_len;
		logic [16:0]    frame_pos;
		logic [15:0]    crc_acc;
		logic [7:0]     crc_rx_low;
		bit             crc_bad;
		int             error_count;
		int             words_checked;
		int             good_frames;
		int             bad_frames;

		function new();
			phase         = PH_HUNT;
			payload_len   = '0;
			frame_pos     = '0;
			crc_acc       = CRC_INIT;
			crc_rx_low    = '0;
			crc_bad       = 1'b0;
			error_count   = 0;
			words_checked = 0;
			good_frames   = 0;
			bad_frames    = 0;
		endfunction

		// Bit-serial CRC-16, reflected, one byte LSB first
		static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
			logic [15:0] c;
			c = crc;
			for (int i = 0; i < 8; i++) begin
				c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
			return c;
		endfunction

		// One accepted rx word: advance the state, queue the words it causes
		function void note_byte(logic [7:0] b);
			logic [16:0] crc_end;
			crc_end = {1'b0, payload_len} + CRC_END_OFS;
			case (phase)
				PH_SAW_A5: begin
					if (b == HDR_SECOND) begin
						pending_words.push_back(frame_word_t'{HDR_FIRST, 1'b1, 1'b0, 1'b0});
						pending_words.push_back(frame_word_t'{HDR_SECOND, 1'b0, 1'b0, 1'b0});
						phase      = PH_LEN_LO;
						frame_pos  = POS_LEN_LO;
						crc_acc    = CRC_INIT;
						crc_bad    = 1'b0;
						crc_rx_low = '0;
					end else begin
						phase = (b == HDR_FIRST) ? PH_SAW_A5 : PH_HUNT;
					end
				end
				PH_LEN_LO: begin
					payload_len = {8'h00, b};
					crc_acc     = crc_step(crc_acc, b);
					frame_pos   = POS_LEN_HI;
					phase       = PH_LEN_HI;
					pending_words.push_back(frame_word_t'{b, 1'b0, 1'b0, 1'b0});
				end
				PH_LEN_HI: begin
					payload_len[15:8] = b;
					crc_acc           = crc_step(crc_acc, b);
					frame_pos         = POS_BODY;
					phase             = PH_BODY;
					pending_words.push_back(frame_word_t'{b, 1'b0, 1'b0, 1'b0});
				end
				PH_BODY: begin
					// covered bytes, then CRC low, then CRC high compares
					if (frame_pos <= crc_end) begin
						crc_acc = crc_step(crc_acc, b);
					end else if (frame_pos == crc_end + 17'd1) begin
						crc_rx_low = b;
					end else if (frame_pos == crc_end + 17'd2) begin
						crc_bad = (crc_rx_low != crc_acc[7:0]) || (b != crc_acc[15:8]);
					end
					if (frame_pos >= {1'b0, payload_len} + LAST_OFS) begin
						pending_words.push_back(frame_word_t'{b, 1'b0, 1'b1, !crc_bad});
						if (crc_bad) begin
							bad_frames++;
						end else begin
							good_frames++;
						end
						phase     = PH_HUNT;
						frame_pos = '0;
					end else begin
						frame_pos = frame_pos + 17'd1;
						pending_words.push_back(frame_word_t'{b, 1'b0, 1'b0, 1'b0});
					end
				end
				default: begin
					phase = (b == HDR_FIRST) ? PH_SAW_A5 : PH_HUNT;
				end
			endcase
		endfunction

		// One accepted tx word against the oldest one owed
		function void check_word(frame_word_t got);
			frame_word_t want;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected tx word, expected none, actual %h first=%b last=%b good=%b",
					$time, got.data, got.first, got.last, got.good);
				error_count++;
				return;
			end
			want = pending_words.pop_front();
			words_checked++;
			if (got.data !== want.data) begin
				$display("%0t: frame_byte expected %h actual %h", $time, want.data, got.data);
				error_count++;
			end
			if (got.first !== want.first) begin
				$display("%0t: first_of_frame expected %b actual %b", $time, want.first, got.first);
				error_count++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last_of_frame expected %b actual %b", $time, want.last, got.last);
				error_count++;
			end
			if (got.good !== want.good) begin
				$display("%0t: frame_good expected %b actual %b", $time, want.good, got.good);
				error_count++;
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	bit              calm;
	int              bytes_sent;
	int              frame_bytes;
	int              big_len;
	logic [7:0]      last_byte;
	frame_scoreboard frame_sb = new();

	sfd_rx_if    rx_ch ();
	sfd_frame_if tx_ch ();

	serial_frame_deframer_crc16 DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	always #6 clk = ~clk;

	// Idle cycles before the next word; none during calm stretches
	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	// Offer one rx word and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		frame_sb.note_byte(b);
		last_byte = b;
		bytes_sent++;
	endtask

	// Full frame of L+27 bytes; damage 1 hits the CRC, 2 hits a payload byte
	task automatic send_frame(input logic [15:0] len, input int unsigned style,
		input int unsigned damage);
		logic [7:0]  body[$];
		logic [15:0] crc;
		logic [7:0]  b;
		crc = CRC_INIT;
		body.push_back(len[7:0]);
		body.push_back(len[15:8]);
		for (int n = 0; n < int'(len) + 20; n++) begin
			case (style)
				0: b = 8'($urandom_range(0, 255));
				1: b = $urandom_range(0, 1) ? HDR_FIRST : HDR_SECOND;
				default: b = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
			endcase
			body.push_back(b);
		end
		foreach (body[i]) begin
			crc = frame_scoreboard::crc_step(crc, body[i]);
		end
		body.push_back(crc[7:0]);
		body.push_back(crc[15:8]);
		body.push_back(8'($urandom_range(0, 255)));
		// length bytes are never damaged so the frame keeps its size
		if (damage == 1) begin
			body[int'(len) + 22 + $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
		end else if (damage == 2) begin
			body[$urandom_range(2, int'(len) + 21)] ^= 8'h01 << $urandom_range(0, 7);
		end
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
		foreach (body[i]) begin
			send_byte(body[i]);
		end
		frame_bytes += int'(len) + 27;
	endtask

	// Line noise, A5-heavy, never forming a header
	task automatic send_noise(input int count);
		logic [7:0] b;
		for (int n = 0; n < count; n++) begin
			b = ($urandom_range(0, 2) == 0) ? HDR_FIRST : 8'($urandom_range(0, 255));
			if (last_byte == HDR_FIRST && b == HDR_SECOND) begin
				b = 8'h00;
			end
			send_byte(b);
		end
	endtask

	// Hold rx off until every owed tx word has arrived
	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		do @(posedge clk); while (frame_sb.pending_words.size() != 0);
	endtask

	// tx sink with random stalls
	initial begin : tx_sink
		frame_word_t got;
		int          gap;
		tx_ch.ready = 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				tx_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tx_ch.ready <= 1'b1;
			do @(posedge clk); while (tx_ch.valid !== 1'b1);
			got = frame_word_t'{tx_ch.frame_byte, tx_ch.first_of_frame,
				tx_ch.last_of_frame, tx_ch.frame_good};
			frame_sb.check_word(got);
		end
	end

	// Ends the run when neither channel moves a word for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Reset, directed cases, random traffic, final verdict
	initial begin : stimulus
		bit big_done;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		calm          = 1'b0;
		bytes_sent    = 0;
		frame_bytes   = 0;
		big_len       = 0;
		last_byte     = 8'h00;
		big_done      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle-line extremes, stray 5A, lone A5, A5 run ahead of a real header
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HDR_SECOND);
		send_byte(HDR_FIRST);
		send_byte(8'h00);
		send_byte(HDR_FIRST);
		send_byte(HDR_FIRST);
		// shortest frame, good; then header-like payload with bad CRC
		send_frame(16'd0, 2, 0);
		send_frame(16'd1, 1, 1);
		wait_drained();

		// random traffic: mostly frames, some noise and broken headers
		frame_bytes = 0;
		while (frame_bytes < BYTE_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			if (!big_done && frame_bytes >= 300) begin
				big_len = $urandom_range(256, 400);
				send_frame(16'(big_len), $urandom_range(0, 2), $urandom_range(0, 2));
				big_done = 1'b1;
				wait_drained();
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: begin
						send_frame(($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12)),
							($urandom_range(0, 7) < 6) ? 0 : $urandom_range(1, 2),
							($urandom_range(0, 7) < 5) ? 0 : $urandom_range(1, 2));
					end
					7, 8: begin
						send_noise($urandom_range(1, 6));
					end
					default: begin
						// A5 or A5 A5 followed by a byte that kills the header
						send_byte(HDR_FIRST);
						if ($urandom_range(0, 1) == 1) begin
							send_byte(HDR_FIRST);
						end
						send_byte($urandom_range(0, 1) ? 8'h00 : 8'h5B);
					end
				endcase
			end
		end

		calm = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run: %0d rx bytes, %0d good and %0d bad frames, %0d tx words checked",
			bytes_sent, frame_sb.good_frames, frame_sb.bad_frames, frame_sb.words_checked);
		$display("Mix: line noise, broken headers, header-like payloads, one %0d-byte frame",
			big_len + 27);
		if (frame_sb.error_count == 0 && frame_sb.pending_words.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_rx_if.sv
hw/rtl/sfd_frame_if.sv
hw/rtl/sfd_core.sv
hw/rtl/sfd_outq.sv
hw/rtl/serial_frame_deframer_crc16.sv
tb/sv/tb_serial_frame_deframer_crc16.sv
